@@ rtl/dtfb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfb_pkg
// Shared types and constants of the depth-tested frame buffer.
// ----------------------------------------------------------------------------
package dtfb_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int ACTION_W  = 3;
    localparam int POS_W     = 12;
    localparam int DEPTH_W   = 24;
    localparam int CHAN_W    = 8;
    localparam int COLOR_W   = 4 * CHAN_W;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    // wide enough for a register value and for the largest dimension (4096)
    localparam int DIM_W     = 13;

    localparam logic [DEPTH_W-1:0] DEPTH_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WR_COLOR = 3'd0,
        ACT_WR_BOTH  = 3'd1,
        ACT_READ     = 3'd2,
        ACT_TEST     = 3'd3,
        ACT_CLEAR    = 3'd4,
        ACT_FLIP     = 3'd5
    } t_action;

    // memory strobes from the sequencer
    typedef struct packed {
        logic color_we;
        logic depth_we;
        logic rd_en;
    } t_mem_ctl;

endpackage

@@ rtl/dtfb_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfb_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dtfb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/dtfb_geom.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfb_geom
// Image size registers, bounds check and the row-times-width multiplier.
// ----------------------------------------------------------------------------
module dtfb_geom
    import dtfb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int WW         = $clog2(MAX_WIDTH + 1),
    parameter int HW         = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [POS_W-1:0]     i_x,
    input  logic [POS_W-1:0]     i_y,
    input  logic [HW-1:0]        i_mul_row,
    output logic [WW-1:0]        o_eff_w,
    output logic [HW-1:0]        o_eff_h,
    output logic                 o_inside,
    output logic [WW+HW-1:0]     o_prod
);

    localparam int PW = WW + HW;

    logic [CFG_W-1:0] r_img_w;
    logic [CFG_W-1:0] r_img_h;
    logic [PW-1:0]    r_prod;
    logic [DIM_W-1:0] w_ext;
    logic [DIM_W-1:0] h_ext;
    logic [DIM_W-1:0] x_ext;
    logic [DIM_W-1:0] y_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= CFG_W'(256);
            r_img_h <= CFG_W'(256);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_img_w <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_img_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_ext   = DIM_W'(r_img_w);
        h_ext   = DIM_W'(r_img_h);
        o_eff_w = (w_ext > DIM_W'(MAX_WIDTH))  ? WW'(MAX_WIDTH)  : WW'(w_ext);
        o_eff_h = (h_ext > DIM_W'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(h_ext);
        x_ext   = DIM_W'(i_x[POS_W-2:0]);
        y_ext   = DIM_W'(i_y[POS_W-2:0]);
        o_inside = !i_x[POS_W-1] && !i_y[POS_W-1]
                   && (x_ext < DIM_W'(o_eff_w)) && (y_ext < DIM_W'(o_eff_h));
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(i_mul_row) * PW'(o_eff_w);
    end

    assign o_prod = r_prod;

endmodule

@@ rtl/dtfb_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfb_ctrl
// Request sequencer: pixel access, clear sweep and vertical flip sweep.
// ----------------------------------------------------------------------------
module dtfb_ctrl
    import dtfb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int WW         = $clog2(MAX_WIDTH + 1),
    parameter int HW         = $clog2(MAX_HEIGHT + 1),
    parameter int DEPTH      = MAX_WIDTH * MAX_HEIGHT,
    parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [POS_W-1:0]    i_pos_x,
    input  logic [POS_W-1:0]    i_pos_y,
    input  logic [DEPTH_W-1:0]  i_depth,
    input  logic [COLOR_W-1:0]  i_color,
    // geometry unit
    output logic [POS_W-1:0]    o_x,
    output logic [POS_W-1:0]    o_y,
    output logic [HW-1:0]       o_mul_row,
    input  logic [WW-1:0]       i_eff_w,
    input  logic [HW-1:0]       i_eff_h,
    input  logic                i_inside,
    input  logic [WW+HW-1:0]    i_prod,
    // memories
    output t_mem_ctl            o_mem,
    output logic [AW-1:0]       o_wr_addr,
    output logic [AW-1:0]       o_rd_addr,
    output logic [COLOR_W-1:0]  o_wr_color,
    output logic [DEPTH_W-1:0]  o_wr_depth,
    input  logic [COLOR_W-1:0]  i_rd_color,
    input  logic [DEPTH_W-1:0]  i_rd_depth,
    // result
    output logic                o_done,
    output logic [COLOR_W-1:0]  o_rd_color,
    output logic                o_closer,
    output logic                o_inside_res
);

    localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

    typedef enum logic [9:0] {
        S_CLEAR   = 10'b00_0000_0001,
        S_IDLE    = 10'b00_0000_0010,
        S_MUL     = 10'b00_0000_0100,
        S_ACC     = 10'b00_0000_1000,
        S_RESP    = 10'b00_0001_0000,
        S_FL_INIT = 10'b00_0010_0000,
        S_FL_BASE = 10'b00_0100_0000,
        S_FL_A    = 10'b00_1000_0000,
        S_FL_B    = 10'b01_0000_0000,
        S_FL_WA   = 10'b10_0000_0000
    } t_state;

    // write-back of the bottom pixel closes a flip step
    logic r_fl_wb, n_fl_wb;

    t_state               r_state, n_state;
    t_action              r_act, n_act;
    logic [POS_W-1:0]     r_x, n_x;
    logic [POS_W-1:0]     r_y, n_y;
    logic [DEPTH_W-1:0]   r_z, n_z;
    logic [COLOR_W-1:0]   r_color, n_color;
    logic                 r_ins, n_ins;
    logic                 r_clr_item, n_clr_item;
    logic [AW-1:0]        r_cnt, n_cnt;
    logic [AW-1:0]        r_bot, n_bot;
    logic [WW-1:0]        r_fx, n_fx;
    logic [HW-1:0]        r_fj, n_fj;
    logic [COLOR_W-1:0]   r_tmp, n_tmp;
    logic                 r_done, n_done;
    logic [COLOR_W-1:0]   r_rd_color, n_rd_color;
    logic                 r_closer, n_closer;
    logic                 r_inside_res, n_inside_res;

    logic [HW-1:0]        half_h;
    logic [AW-1:0]        pix_addr;
    logic                 accept;

    assign half_h   = i_eff_h >> 1;
    assign pix_addr = AW'(i_prod) + AW'(r_x[POS_W-2:0]);
    assign accept   = i_start && (r_state == S_IDLE) && !r_fl_wb;

    always_comb begin
        n_state      = r_state;
        n_act        = r_act;
        n_x          = r_x;
        n_y          = r_y;
        n_z          = r_z;
        n_color      = r_color;
        n_ins        = r_ins;
        n_clr_item   = r_clr_item;
        n_cnt        = r_cnt;
        n_bot        = r_bot;
        n_fx         = r_fx;
        n_fj         = r_fj;
        n_tmp        = r_tmp;
        n_fl_wb      = 1'b0;
        n_done       = 1'b0;
        n_rd_color   = r_rd_color;
        n_closer     = r_closer;
        n_inside_res = r_inside_res;
        o_mul_row    = '0;
        o_mem        = '0;
        o_wr_addr    = pix_addr;
        o_rd_addr    = pix_addr;
        o_wr_color   = r_color;
        o_wr_depth   = r_z;

        if (r_fl_wb) begin
            // second half of a swap: bottom pixel takes the saved top color
            o_wr_addr      = r_bot;
            o_wr_color     = r_tmp;
            o_mem.color_we = 1'b1;
            n_cnt          = r_cnt + AW'(1);
            n_state        = S_FL_A;
            if (r_fx == i_eff_w - WW'(1)) begin
                n_fx  = '0;
                n_fj  = r_fj + HW'(1);
                n_bot = r_bot + AW'(1) - AW'({i_eff_w, 1'b0});
                if (r_fj == half_h - HW'(1)) begin
                    n_state      = S_IDLE;
                    n_done       = 1'b1;
                    n_rd_color   = '0;
                    n_closer     = 1'b0;
                    n_inside_res = 1'b0;
                end
            end else begin
                n_fx  = r_fx + WW'(1);
                n_bot = r_bot + AW'(1);
            end
        end else begin
            case (r_state)
                S_CLEAR: begin
                    o_wr_addr      = r_cnt;
                    o_wr_color     = '0;
                    o_wr_depth     = DEPTH_MIN;
                    o_mem.color_we = 1'b1;
                    o_mem.depth_we = 1'b1;
                    n_cnt          = r_cnt + AW'(1);
                    if (r_cnt == CLR_LAST) begin
                        n_state    = S_IDLE;
                        n_clr_item = 1'b0;
                        if (r_clr_item) begin
                            n_done       = 1'b1;
                            n_rd_color   = '0;
                            n_closer     = 1'b0;
                            n_inside_res = 1'b0;
                        end
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        n_act   = t_action'(i_action);
                        n_x     = i_pos_x;
                        n_y     = i_pos_y;
                        n_z     = i_depth;
                        n_color = i_color;
                        case (t_action'(i_action))
                            ACT_WR_COLOR, ACT_WR_BOTH, ACT_READ, ACT_TEST: begin
                                n_state = S_MUL;
                            end
                            ACT_CLEAR: begin
                                n_state    = S_CLEAR;
                                n_cnt      = '0;
                                n_clr_item = 1'b1;
                            end
                            ACT_FLIP: begin
                                n_state = S_FL_INIT;
                            end
                            default: begin
                                // unused codes: zero result, no state change
                                n_done       = 1'b1;
                                n_rd_color   = '0;
                                n_closer     = 1'b0;
                                n_inside_res = 1'b0;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    o_mul_row = HW'(r_y[POS_W-2:0]);
                    n_ins     = i_inside;
                    n_state   = S_ACC;
                end
                S_ACC: begin
                    case (r_act)
                        ACT_WR_COLOR, ACT_WR_BOTH: begin
                            o_mem.color_we = r_ins;
                            o_mem.depth_we = r_ins && (r_act == ACT_WR_BOTH);
                            n_state        = S_IDLE;
                            n_done         = 1'b1;
                            n_rd_color     = '0;
                            n_closer       = 1'b0;
                            n_inside_res   = r_ins;
                        end
                        default: begin
                            o_mem.rd_en = 1'b1;
                            n_state     = S_RESP;
                        end
                    endcase
                end
                S_RESP: begin
                    n_state      = S_IDLE;
                    n_done       = 1'b1;
                    n_rd_color   = (r_act == ACT_READ && r_ins) ? i_rd_color : '0;
                    n_closer     = (r_act == ACT_TEST) && r_ins
                                   && ($signed(i_rd_depth) < $signed(r_z));
                    n_inside_res = r_ins;
                end
                S_FL_INIT: begin
                    o_mul_row = i_eff_h - HW'(1);
                    if (i_eff_w == '0 || half_h == '0) begin
                        n_state      = S_IDLE;
                        n_done       = 1'b1;
                        n_rd_color   = '0;
                        n_closer     = 1'b0;
                        n_inside_res = 1'b0;
                    end else begin
                        n_state = S_FL_BASE;
                    end
                end
                S_FL_BASE: begin
                    // bottom row base (h-1)*w comes out of the multiplier
                    n_bot   = AW'(i_prod);
                    n_cnt   = '0;
                    n_fx    = '0;
                    n_fj    = '0;
                    n_state = S_FL_A;
                end
                S_FL_A: begin
                    o_rd_addr   = r_cnt;
                    o_mem.rd_en = 1'b1;
                    n_state     = S_FL_B;
                end
                S_FL_B: begin
                    o_rd_addr   = r_bot;
                    o_mem.rd_en = 1'b1;
                    n_tmp       = i_rd_color;
                    n_state     = S_FL_WA;
                end
                S_FL_WA: begin
                    o_wr_addr      = r_cnt;
                    o_wr_color     = i_rd_color;
                    o_mem.color_we = 1'b1;
                    n_fl_wb        = 1'b1;
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_cnt      <= '0;
            r_clr_item <= 1'b0;
            r_fl_wb    <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_clr_item <= n_clr_item;
            r_fl_wb    <= n_fl_wb;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act        <= n_act;
        r_x          <= n_x;
        r_y          <= n_y;
        r_z          <= n_z;
        r_color      <= n_color;
        r_ins        <= n_ins;
        r_bot        <= n_bot;
        r_fx         <= n_fx;
        r_fj         <= n_fj;
        r_tmp        <= n_tmp;
        r_rd_color   <= n_rd_color;
        r_closer     <= n_closer;
        r_inside_res <= n_inside_res;
    end

    assign o_busy       = (r_state != S_IDLE) || r_fl_wb;
    assign o_x          = r_x;
    assign o_y          = r_y;
    assign o_done       = r_done;
    assign o_rd_color   = r_rd_color;
    assign o_closer     = r_closer;
    assign o_inside_res = r_inside_res;

    // a result only leaves when the sequencer has come back to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE) && !r_fl_wb)
        else $error("result strobe outside idle");

    // no memory write while waiting for a request
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !r_fl_wb) |-> !o_mem.color_we && !o_mem.depth_we)
        else $error("memory write in idle");

    // flip swaps always pair an upper pixel with a lower one
    a_flip_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FL_A) |-> (r_cnt < r_bot))
        else $error("flip pair out of order");

    // pixel writes answer after the S_MUL and S_ACC states
    a_write_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_action == ACT_WR_COLOR || i_action == ACT_WR_BOTH))
        |-> ##3 r_done)
        else $error("write result late");

    // reads and depth tests answer after the S_MUL, S_ACC and S_RESP states
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_action == ACT_READ || i_action == ACT_TEST)) |-> ##4 r_done)
        else $error("read result late");

endmodule

@@ rtl/depth_tested_frame_buffer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_tested_frame_buffer_top
// Pixel store with RGBA color and Q8.16 depth memories, depth test,
// clear and vertical flip.
//
// channel   handshake                  payload
// request   start / busy               i_action, i_pos_x/y, i_depth, i_new_*
// result    o_done (one-cycle strobe)  o_read_*, o_closer, o_inside_res
// config    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Write requests answer after the multiplier stage and the memory access;
// reads and depth tests also wait for the registered read data. Flip swaps
// w*floor(h/2) pixel pairs, four memory accesses per swapped pair on the
// single read port. Clear writes MAX_WIDTH*MAX_HEIGHT entries, one memory
// entry per cycle. After reset the same clearing pass runs with busy high;
// configuration writes are taken at any time.
// One request is in flight at a time; results cannot be held off.
// ----------------------------------------------------------------------------
module depth_tested_frame_buffer_top
    import dtfb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [ACTION_W-1:0]  i_action,
    input  logic [POS_W-1:0]     i_pos_x,
    input  logic [POS_W-1:0]     i_pos_y,
    input  logic [DEPTH_W-1:0]   i_depth,
    input  logic [CHAN_W-1:0]    i_new_red,
    input  logic [CHAN_W-1:0]    i_new_green,
    input  logic [CHAN_W-1:0]    i_new_blue,
    input  logic [CHAN_W-1:0]    i_new_alpha,
    output logic                 o_done,
    output logic [CHAN_W-1:0]    o_read_red,
    output logic [CHAN_W-1:0]    o_read_green,
    output logic [CHAN_W-1:0]    o_read_blue,
    output logic [CHAN_W-1:0]    o_read_alpha,
    output logic                 o_closer,
    output logic                 o_inside_res,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [POS_W-1:0]   item_x;
    logic [POS_W-1:0]   item_y;
    logic [HW-1:0]      mul_row;
    logic [WW-1:0]      eff_w;
    logic [HW-1:0]      eff_h;
    logic               pix_inside;
    logic [WW+HW-1:0]   prod;
    t_mem_ctl           mem;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic [COLOR_W-1:0] wr_color;
    logic [DEPTH_W-1:0] wr_depth;
    logic [COLOR_W-1:0] rd_color;
    logic [DEPTH_W-1:0] rd_depth;
    logic [COLOR_W-1:0] res_color;

    assign o_cfg_ready = 1'b1;

    dtfb_geom #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .WW         (WW),
        .HW         (HW)
    ) u_geom (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_x         (item_x),
        .i_y         (item_y),
        .i_mul_row   (mul_row),
        .o_eff_w     (eff_w),
        .o_eff_h     (eff_h),
        .o_inside    (pix_inside),
        .o_prod      (prod)
    );

    dtfb_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .WW         (WW),
        .HW         (HW),
        .DEPTH      (DEPTH),
        .AW         (AW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .o_busy       (busy),
        .i_action     (i_action),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_depth      (i_depth),
        .i_color      ({i_new_red, i_new_green, i_new_blue, i_new_alpha}),
        .o_x          (item_x),
        .o_y          (item_y),
        .o_mul_row    (mul_row),
        .i_eff_w      (eff_w),
        .i_eff_h      (eff_h),
        .i_inside     (pix_inside),
        .i_prod       (prod),
        .o_mem        (mem),
        .o_wr_addr    (wr_addr),
        .o_rd_addr    (rd_addr),
        .o_wr_color   (wr_color),
        .o_wr_depth   (wr_depth),
        .i_rd_color   (rd_color),
        .i_rd_depth   (rd_depth),
        .o_done       (o_done),
        .o_rd_color   (res_color),
        .o_closer     (o_closer),
        .o_inside_res (o_inside_res)
    );

    dtfb_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_color_ram (
        .i_clk     (i_clk),
        .i_we      (mem.color_we),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_color),
        .i_rd_en   (mem.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_color)
    );

    dtfb_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_depth_ram (
        .i_clk     (i_clk),
        .i_we      (mem.depth_we),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_depth),
        .i_rd_en   (mem.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_depth)
    );

    assign o_read_red   = res_color[4*CHAN_W-1:3*CHAN_W];
    assign o_read_green = res_color[3*CHAN_W-1:2*CHAN_W];
    assign o_read_blue  = res_color[2*CHAN_W-1:CHAN_W];
    assign o_read_alpha = res_color[CHAN_W-1:0];

endmodule

@@ sim/depth_tested_frame_buffer_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_tested_frame_buffer_top_test
// Self-checking bench for the depth-tested frame buffer. Directed requests
// cover depth compare, pixel write/read, bounds, flip, clear and the spare
// action codes. Random pixel traffic then runs over a range of image sizes.
// Each reply is scored against a local model of the color and depth stores.
// ----------------------------------------------------------------------------
module depth_tested_frame_buffer_top_test;
    import dtfb_pkg::*;

    localparam int MAX_W         = DEF_MAX_WIDTH;
    localparam int MAX_H         = DEF_MAX_HEIGHT;
    localparam int STORE_N       = MAX_W * MAX_H;
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int FLIP_AREA_CAP = 1024;   // random flips only on small images
    localparam int PHASE_ITEMS   = 62;

    localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;
    localparam logic [DEPTH_W-1:0]  DEPTH_MAX   = {1'b0, {(DEPTH_W-1){1'b1}}};

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [POS_W-1:0]    x;
        logic [POS_W-1:0]    y;
        logic [DEPTH_W-1:0]  z;
        logic [COLOR_W-1:0]  rgba;
    } t_pixel_req;

    typedef struct packed {
        logic [COLOR_W-1:0] rgba;
        logic               closer;
        logic               in_image;
    } t_pixel_reply;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 start        = 1'b0;
    logic                 busy;
    logic [ACTION_W-1:0]  i_action     = '0;
    logic [POS_W-1:0]     i_pos_x      = '0;
    logic [POS_W-1:0]     i_pos_y      = '0;
    logic [DEPTH_W-1:0]   i_depth      = '0;
    logic [CHAN_W-1:0]    i_new_red    = '0;
    logic [CHAN_W-1:0]    i_new_green  = '0;
    logic [CHAN_W-1:0]    i_new_blue   = '0;
    logic [CHAN_W-1:0]    i_new_alpha  = '0;
    logic                 o_done;
    logic [CHAN_W-1:0]    o_read_red;
    logic [CHAN_W-1:0]    o_read_green;
    logic [CHAN_W-1:0]    o_read_blue;
    logic [CHAN_W-1:0]    o_read_alpha;
    logic                 o_closer;
    logic                 o_inside_res;
    logic                 i_cfg_valid  = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index  = '0;
    logic [CFG_W-1:0]     i_cfg_data   = '0;

    // model of the pixel stores
    logic [COLOR_W-1:0] fb_color [STORE_N];
    logic [DEPTH_W-1:0] fb_depth [STORE_N];
    int                 img_width  = 256;
    int                 img_height = 256;

    t_pixel_reply       expected_replies [$];
    int                 err_count     = 0;
    int                 cycle_count   = 0;
    int                 clears_left   = 3;
    bit                 steady_sender = 1'b0;
    logic [POS_W-1:0]   recent_x      = '0;
    logic [POS_W-1:0]   recent_y      = '0;

    depth_tested_frame_buffer_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_depth      (i_depth),
        .i_new_red    (i_new_red),
        .i_new_green  (i_new_green),
        .i_new_blue   (i_new_blue),
        .i_new_alpha  (i_new_alpha),
        .o_done       (o_done),
        .o_read_red   (o_read_red),
        .o_read_green (o_read_green),
        .o_read_blue  (o_read_blue),
        .o_read_alpha (o_read_alpha),
        .o_closer     (o_closer),
        .o_inside_res (o_inside_res),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int eff_width();
        return (img_width > MAX_W) ? MAX_W : img_width;
    endfunction

    function automatic int eff_height();
        return (img_height > MAX_H) ? MAX_H : img_height;
    endfunction

    function automatic void clear_model();
        for (int i = 0; i < STORE_N; i++) begin
            fb_color[i] = '0;
            fb_depth[i] = DEPTH_MIN;
        end
    endfunction

    // updates the model stores and returns the reply the block should give
    function automatic t_pixel_reply apply_pixel_request(t_pixel_req req);
        int                 w;
        int                 h;
        int                 xi;
        int                 yi;
        int                 a;
        int                 b;
        logic               hit;
        logic [COLOR_W-1:0] swap;
        t_pixel_reply       rep;
        w   = eff_width();
        h   = eff_height();
        xi  = $signed(req.x);
        yi  = $signed(req.y);
        hit = (xi >= 0) && (yi >= 0) && (xi < w) && (yi < h);
        a   = hit ? yi * w + xi : 0;
        rep = '0;
        case (req.action)
            ACT_WR_COLOR: begin
                if (hit) fb_color[a] = req.rgba;
                rep.in_image = hit;
            end
            ACT_WR_BOTH: begin
                if (hit) begin
                    fb_color[a] = req.rgba;
                    fb_depth[a] = req.z;
                end
                rep.in_image = hit;
            end
            ACT_READ: begin
                if (hit) rep.rgba = fb_color[a];
                rep.in_image = hit;
            end
            ACT_TEST: begin
                rep.closer   = hit && ($signed(fb_depth[a]) < $signed(req.z));
                rep.in_image = hit;
            end
            ACT_CLEAR: begin
                clear_model();
            end
            ACT_FLIP: begin
                for (int col = 0; col < w; col++) begin
                    for (int j = 0; j < h / 2; j++) begin
                        a = j * w + col;
                        b = (h - 1 - j) * w + col;
                        swap        = fb_color[a];
                        fb_color[a] = fb_color[b];
                        fb_color[b] = swap;
                    end
                end
            end
            default: ;
        endcase
        return rep;
    endfunction

    function automatic t_pixel_req make_req(logic [ACTION_W-1:0] action, int x, int y,
                                            int z, logic [COLOR_W-1:0] rgba);
        t_pixel_req req;
        req.action = action;
        req.x      = POS_W'(x);
        req.y      = POS_W'(y);
        req.z      = DEPTH_W'(z);
        req.rgba   = rgba;
        return req;
    endfunction

    task automatic send_pixel_request(t_pixel_req req);
        i_action    <= req.action;
        i_pos_x     <= req.x;
        i_pos_y     <= req.y;
        i_depth     <= req.z;
        i_new_red   <= req.rgba[31:24];
        i_new_green <= req.rgba[23:16];
        i_new_blue  <= req.rgba[15:8];
        i_new_alpha <= req.rgba[7:0];
        start       <= 1'b1;
        do @(posedge i_clk); while (busy);
        expected_replies.push_back(apply_pixel_request(req));
        if (!steady_sender && $urandom_range(99) < 30) begin
            start <= 1'b0;
            repeat ($urandom_range(5, 1)) @(posedge i_clk);
        end
    endtask

    // hold off new requests until every reply is in and the block is idle
    task automatic drain_replies();
        start <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_IMAGE_WIDTH) img_width = value & 'h1FF;
        else img_height = value & 'h1FF;
    endtask

    function automatic logic [POS_W-1:0] random_coord(int dim);
        int r;
        r = $urandom_range(99);
        if (r < 15) return POS_W'($urandom);
        if (r < 30) return POS_W'((r % 2) ? -1 : dim);   // just outside
        if (dim == 0) return '0;
        return POS_W'($urandom_range(dim - 1));
    endfunction

    function automatic t_pixel_req random_pixel_request();
        t_pixel_req req;
        int         w;
        int         h;
        int         roll;
        int         xi;
        int         yi;
        w        = eff_width();
        h        = eff_height();
        req.rgba = $urandom;
        req.z    = DEPTH_W'($urandom);
        if ($urandom_range(99) < 35) begin
            req.x = recent_x;
            req.y = recent_y;
        end else begin
            req.x = random_coord(w);
            req.y = random_coord(h);
        end
        roll = $urandom_range(999);
        if (roll < 220) req.action = ACT_WR_COLOR;
        else if (roll < 440) req.action = ACT_WR_BOTH;
        else if (roll < 700) req.action = ACT_READ;
        else if (roll < 950) req.action = ACT_TEST;
        else if (roll < 975) req.action = (w * (h / 2) <= FLIP_AREA_CAP) ? ACT_FLIP : ACT_READ;
        else if (roll < 980 && clears_left > 0) begin
            req.action = ACT_CLEAR;
            clears_left--;
        end else req.action = roll[0] ? ACT_SPARE_6 : ACT_SPARE_7;

        xi = $signed(req.x);
        yi = $signed(req.y);
        if (req.action == ACT_TEST && xi >= 0 && yi >= 0 && xi < w && yi < h) begin
            roll = $urandom_range(99);
            // land on or next to the stored depth to hit the strict compare
            if (roll < 40) req.z = DEPTH_W'(fb_depth[yi * w + xi] + $urandom_range(2) - 1);
            else if (roll < 50) req.z = roll[0] ? DEPTH_MAX : DEPTH_MIN;
        end
        if (req.action == ACT_WR_COLOR || req.action == ACT_WR_BOTH) begin
            recent_x = req.x;
            recent_y = req.y;
        end
        return req;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endfunction

    always @(posedge i_clk) begin : reply_check
        t_pixel_reply want;
        if (i_rst_n && o_done) begin
            if (expected_replies.size() == 0) begin
                $error("reply with no request outstanding");
                err_count++;
            end else begin
                want = expected_replies.pop_front();
                check_field("read_red", want.rgba[31:24], o_read_red);
                check_field("read_green", want.rgba[23:16], o_read_green);
                check_field("read_blue", want.rgba[15:8], o_read_blue);
                check_field("read_alpha", want.rgba[7:0], o_read_alpha);
                check_field("closer", want.closer, o_closer);
                check_field("inside_res", want.in_image, o_inside_res);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // store starts at the most negative depth
    task automatic test_depth_compare();
        send_pixel_request(make_req(ACT_TEST, 0, 0, DEPTH_MIN, '0));
        send_pixel_request(make_req(ACT_TEST, 0, 0, DEPTH_MIN + 1, '0));
        send_pixel_request(make_req(ACT_WR_BOTH, 0, 0, DEPTH_MAX, 32'hFFFF_FFFF));
        send_pixel_request(make_req(ACT_TEST, 0, 0, DEPTH_MAX, '0));
    endtask

    task automatic test_write_read();
        send_pixel_request(make_req(ACT_READ, 0, 0, 0, '0));
        send_pixel_request(make_req(ACT_WR_COLOR, 255, 255, -1, 32'h5AA5_C33C));
        send_pixel_request(make_req(ACT_READ, 255, 255, 0, '0));
        send_pixel_request(make_req(ACT_WR_BOTH, 255, 0, 0, 32'h1234_5678));
        send_pixel_request(make_req(ACT_WR_COLOR, 0, 255, 7, 32'h8765_4321));
    endtask

    // x equal to width or y equal to height must count as outside
    task automatic test_bounds();
        send_pixel_request(make_req(ACT_WR_BOTH, 256, 0, DEPTH_MAX, 32'hDEAD_BEEF));
        send_pixel_request(make_req(ACT_WR_COLOR, 0, 256, 0, 32'hCAFE_F00D));
        send_pixel_request(make_req(ACT_READ, -1, 0, 0, '0));
        send_pixel_request(make_req(ACT_READ, 0, -2048, 0, '0));
        send_pixel_request(make_req(ACT_TEST, 2047, 2047, DEPTH_MAX, '0));
        send_pixel_request(make_req(ACT_TEST, -2048, 5, DEPTH_MAX, '0));
    endtask

    // full-size flip; depth stays where it was
    task automatic test_flip();
        send_pixel_request(make_req(ACT_FLIP, 0, 0, 0, '0));
        send_pixel_request(make_req(ACT_READ, 0, 0, 0, '0));
        send_pixel_request(make_req(ACT_READ, 255, 255, 0, '0));
        send_pixel_request(make_req(ACT_READ, 0, 255, 0, '0));
        send_pixel_request(make_req(ACT_TEST, 255, 0, 1, '0));
    endtask

    task automatic test_spare_actions();
        send_pixel_request(make_req(ACT_SPARE_6, 0, 0, DEPTH_MAX, 32'hFFFF_FFFF));
        send_pixel_request(make_req(ACT_SPARE_7, 255, 255, -1, 32'hFFFF_FFFF));
    endtask

    task automatic test_clear();
        send_pixel_request(make_req(ACT_CLEAR, 3, 3, 0, 32'hFFFF_FFFF));
        send_pixel_request(make_req(ACT_READ, 0, 255, 0, '0));
        send_pixel_request(make_req(ACT_TEST, 0, 0, DEPTH_MIN + 1, '0));
    endtask

    task automatic test_random_traffic();
        int widths  [12] = '{16, 1, 0, 300, 5, 37, 256, 2, 511, 0, 9, 23};
        int heights [12] = '{16, 1, 0, 3, 511, 9, 256, 256, 511, 5, 0, 17};
        for (int p = 0; p < 12; p++) begin
            drain_replies();
            write_register(CFG_IMAGE_WIDTH, widths[p]);
            write_register(CFG_IMAGE_HEIGHT, heights[p]);
            steady_sender = (p == 6 || p == 7);
            recent_x = '0;
            recent_y = '0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_pixel_request(random_pixel_request());
                if ($urandom_range(99) < 2) drain_replies();
            end
        end
        steady_sender = 1'b0;
    endtask

    initial begin
        clear_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_depth_compare();
        test_write_read();
        test_bounds();
        test_flip();
        test_spare_actions();
        test_clear();
        test_random_traffic();
        drain_replies();
        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
